### src/csig_pkg.sv
// Shared definitions for the coprime stride index generator.
// Holds widths, register indexes, micro-op and condition codes, and the microcode ROM.
// No dependencies.
package csig_pkg;

  localparam int INDEX_BITS     = 16;
  localparam int MAX_SAMPLES    = 64;
  localparam int COUNT_BITS     = 7;
  localparam int RAND_BITS      = 31;
  localparam int PROD_BITS      = RAND_BITS + INDEX_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int PC_BITS        = 5;

  localparam logic [INDEX_BITS-1:0] MODULUS_RESET      = INDEX_BITS'(1024);
  localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RESET = COUNT_BITS'(MAX_SAMPLES);

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS      = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT = CFG_INDEX_BITS'(1);

  typedef logic [PC_BITS-1:0] pc_t;

  // Datapath micro-ops
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL,
    OP_CAND,
    OP_LOAD_AB,
    OP_REM_A,
    OP_CAP_A,
    OP_REM_B,
    OP_CAP_B,
    OP_INC,
    OP_REM_S,
    OP_CAP_S,
    OP_EMIT,
    OP_ZERO
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_M_ZERO,
    C_REM_BUSY,
    C_A_ZERO,
    C_B_NONZERO,
    C_GCD_ONE,
    C_CNT_ZERO,
    C_EMIT_PEND
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic m_zero;
    logic rem_busy;
    logic a_zero;
    logic b_nonzero;
    logic gcd_one;
    logic cnt_zero;
    logic emit_pend;
  } flags_t;

  // Program addresses
  localparam pc_t S_ACCEPT  = pc_t'(0);
  localparam pc_t S_MUL     = pc_t'(1);
  localparam pc_t S_CAND    = pc_t'(2);
  localparam pc_t S_LOAD_AB = pc_t'(3);
  localparam pc_t S_REM_A   = pc_t'(4);
  localparam pc_t S_WAIT_A  = pc_t'(5);
  localparam pc_t S_TEST_A  = pc_t'(6);
  localparam pc_t S_REM_B   = pc_t'(7);
  localparam pc_t S_WAIT_B  = pc_t'(8);
  localparam pc_t S_TEST_B  = pc_t'(9);
  localparam pc_t S_VERDICT = pc_t'(10);
  localparam pc_t S_INC     = pc_t'(11);
  localparam pc_t S_FOUND   = pc_t'(12);
  localparam pc_t S_WAIT_S  = pc_t'(13);
  localparam pc_t S_CHK_CNT = pc_t'(14);
  localparam pc_t S_EMIT    = pc_t'(15);
  localparam pc_t S_DONE    = pc_t'(16);
  localparam pc_t S_ZERO    = pc_t'(17);
  localparam pc_t S_LAST    = S_ZERO;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      S_ACCEPT:  w = '{OP_ACCEPT,  C_NO_IN,     S_ACCEPT};
      S_MUL:     w = '{OP_MUL,     C_M_ZERO,    S_ZERO};
      S_CAND:    w = '{OP_CAND,    C_NEVER,     S_ACCEPT};
      S_LOAD_AB: w = '{OP_LOAD_AB, C_NEVER,     S_ACCEPT};
      S_REM_A:   w = '{OP_REM_A,   C_NEVER,     S_ACCEPT};
      S_WAIT_A:  w = '{OP_CAP_A,   C_REM_BUSY,  S_WAIT_A};
      S_TEST_A:  w = '{OP_NOP,     C_A_ZERO,    S_VERDICT};
      S_REM_B:   w = '{OP_REM_B,   C_NEVER,     S_ACCEPT};
      S_WAIT_B:  w = '{OP_CAP_B,   C_REM_BUSY,  S_WAIT_B};
      S_TEST_B:  w = '{OP_NOP,     C_B_NONZERO, S_REM_A};
      S_VERDICT: w = '{OP_NOP,     C_GCD_ONE,   S_FOUND};
      S_INC:     w = '{OP_INC,     C_ALWAYS,    S_LOAD_AB};
      S_FOUND:   w = '{OP_REM_S,   C_NEVER,     S_ACCEPT};
      S_WAIT_S:  w = '{OP_CAP_S,   C_REM_BUSY,  S_WAIT_S};
      S_CHK_CNT: w = '{OP_NOP,     C_CNT_ZERO,  S_ACCEPT};
      S_EMIT:    w = '{OP_EMIT,    C_EMIT_PEND, S_EMIT};
      S_DONE:    w = '{OP_NOP,     C_ALWAYS,    S_ACCEPT};
      S_ZERO:    w = '{OP_ZERO,    C_ALWAYS,    S_CHK_CNT};
      default:   w = '{OP_NOP,     C_ALWAYS,    S_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

### src/csig_rem.sv
// Iterative remainder unit: one restoring-division bit per cycle.
// Depends on csig_pkg for INDEX_BITS.
module csig_rem (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [csig_pkg::INDEX_BITS-1:0] dividend,
  input  logic [csig_pkg::INDEX_BITS-1:0] divisor,
  output logic                            busy,
  output logic [csig_pkg::INDEX_BITS-1:0] remainder
);
  import csig_pkg::*;

  localparam int CNT_BITS = $clog2(INDEX_BITS + 1);

  logic [INDEX_BITS-1:0] rem;
  logic [INDEX_BITS-1:0] dvd;
  logic [INDEX_BITS-1:0] dsr;
  logic [CNT_BITS-1:0]   cnt;
  logic [INDEX_BITS:0]   trial;

  assign trial     = {rem, dvd[INDEX_BITS-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(INDEX_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_BITS'(1);
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      // subtract when the partial remainder reaches the divisor
      if (trial >= {1'b0, dsr}) begin
        rem <= INDEX_BITS'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[INDEX_BITS-1:0];
      end
      dvd <= {dvd[INDEX_BITS-2:0], 1'b0};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit restarted while busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("remainder unit busy with zero bit count");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == CNT_BITS'(1) && !start |=> !busy)
    else $error("remainder unit failed to finish");

endmodule

### src/csig_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on csig_pkg for the ROM, micro-op and condition codes.
module csig_seq (
  input  logic              clk,
  input  logic              rst,
  input  csig_pkg::flags_t  flags,
  output csig_pkg::op_t     op
);
  import csig_pkg::*;

  pc_t    pc;
  pc_t    pc_next;
  uword_t word;
  logic   take;

  assign word = ucode_rom(pc);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !flags.in_valid;
      C_M_ZERO:    take = flags.m_zero;
      C_REM_BUSY:  take = flags.rem_busy;
      C_A_ZERO:    take = flags.a_zero;
      C_B_NONZERO: take = flags.b_nonzero;
      C_GCD_ONE:   take = flags.gcd_one;
      C_CNT_ZERO:  take = flags.cnt_zero;
      C_EMIT_PEND: take = flags.emit_pend;
      default:     take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= S_LAST)
    else $error("step counter left the program");
  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    pc == S_WAIT_A && flags.rem_busy |=> pc == S_WAIT_A)
    else $error("sequencer left a remainder wait early");
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    pc == S_ACCEPT && !flags.in_valid |=> pc == S_ACCEPT)
    else $error("sequencer left idle without an item");

endmodule

### src/coprime_stride_index_generator.sv
// Coprime stride index generator, top level: config registers, datapath, output register.
// Steps: setup (accept, multiply, scale), then per stride candidate a gcd loop whose
// remainder steps use the shared 16-bit remainder unit, then reduction of the stride,
// then one index per cycle for sample_count indices while out_ready does not stall them.
// One item at a time: the next item is taken only after the last index is loaded.
// Reset: synchronous, active high; modulus 1024, sample_count 64, sequencer idle.
module coprime_stride_index_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [csig_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [csig_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [csig_pkg::RAND_BITS-1:0]      stride_random,
  input  logic [csig_pkg::RAND_BITS-1:0]      start_random,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csig_pkg::INDEX_BITS-1:0]     sample_index,
  output logic                                last
);
  import csig_pkg::*;

  // configuration registers
  logic [INDEX_BITS-1:0] modulus;
  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] cfg_count;

  // datapath registers
  logic [RAND_BITS-1:0]  r1;
  logic [INDEX_BITS-1:0] span;
  logic [PROD_BITS-1:0]  prod;
  logic [INDEX_BITS-1:0] cand;
  logic [INDEX_BITS-1:0] stride;
  logic [INDEX_BITS-1:0] smod;
  logic [INDEX_BITS-1:0] cur;
  logic [INDEX_BITS-1:0] gcd_left;
  logic [INDEX_BITS-1:0] gcd_right;
  logic [COUNT_BITS-1:0] emitted_count;

  op_t                   op;
  flags_t                flags;
  logic                  rem_start;
  logic                  rem_busy;
  logic [INDEX_BITS-1:0] rem_dividend;
  logic [INDEX_BITS-1:0] rem_divisor;
  logic [INDEX_BITS-1:0] rem_result;
  logic                  accept;
  logic                  emit_load;
  logic                  is_last;
  logic [INDEX_BITS:0]   step_sum;
  logic [INDEX_BITS-1:0] cur_next;

  // Config writes; sample_count saturates at the run-length cap.
  assign cfg_count = cfg_data[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= MODULUS_RESET;
      sample_count <= SAMPLE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODULUS:      modulus <= cfg_data[INDEX_BITS-1:0];
        REG_SAMPLE_COUNT: sample_count <= (cfg_count > COUNT_BITS'(MAX_SAMPLES)) ?
                                          COUNT_BITS'(MAX_SAMPLES) : cfg_count;
        default:          ;
      endcase
    end
  end

  csig_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  // Shared remainder unit: a % b, b % a, or stride % modulus.
  always_comb begin
    rem_start    = 1'b0;
    rem_dividend = gcd_left;
    rem_divisor  = gcd_right;
    case (op)
      OP_REM_A: begin
        rem_start = 1'b1;
      end
      OP_REM_B: begin
        rem_start    = 1'b1;
        rem_dividend = gcd_right;
        rem_divisor  = gcd_left;
      end
      OP_REM_S: begin
        rem_start    = 1'b1;
        rem_dividend = cand;
        rem_divisor  = modulus;
      end
      default: ;
    endcase
  end

  csig_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .busy      (rem_busy),
    .remainder (rem_result)
  );

  assign in_ready = (op == OP_ACCEPT);
  assign accept   = in_valid && in_ready;

  // Output stage: load when the register is empty or being drained.
  assign emit_load = (op == OP_EMIT) && (!out_valid || out_ready);
  assign is_last   = (emitted_count + COUNT_BITS'(1)) == sample_count;

  // Next index: cur and the reduced stride are both below modulus.
  assign step_sum = {1'b0, cur} + {1'b0, smod};
  assign cur_next = (step_sum >= {1'b0, modulus}) ?
                    INDEX_BITS'(step_sum - {1'b0, modulus}) : step_sum[INDEX_BITS-1:0];

  always_comb begin
    flags.in_valid  = in_valid;
    flags.m_zero    = (modulus == '0);
    flags.rem_busy  = rem_busy;
    flags.a_zero    = (gcd_left == '0);
    flags.b_nonzero = (gcd_right != '0);
    // At either exit of the loop one operand is zero, so this is the coprime test.
    flags.gcd_one   = (gcd_left == INDEX_BITS'(1)) || (gcd_right == INDEX_BITS'(1));
    flags.cnt_zero  = (sample_count == '0);
    // hold in the emit step until the last index of the run is loaded
    flags.emit_pend = !(emit_load && is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stride        <= '0;
      cur           <= '0;
      emitted_count <= '0;
      gcd_left      <= '0;
      gcd_right     <= '0;
    end else begin
      case (op)
        OP_ACCEPT: begin
          if (accept) begin
            // start index: random word masked with modulus minus one
            cur           <= start_random[INDEX_BITS-1:0] & (modulus - INDEX_BITS'(1));
            emitted_count <= '0;
          end
        end
        OP_LOAD_AB: begin
          gcd_left  <= cand;
          gcd_right <= modulus;
        end
        OP_CAP_A: begin
          if (!rem_busy) begin
            gcd_left <= rem_result;
          end
        end
        OP_CAP_B: begin
          if (!rem_busy) begin
            gcd_right <= rem_result;
          end
        end
        OP_REM_S: begin
          stride <= cand;
        end
        OP_ZERO: begin
          stride <= '0;
          cur    <= '0;
        end
        OP_EMIT: begin
          if (emit_load) begin
            cur           <= cur_next;
            emitted_count <= emitted_count + COUNT_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (accept) begin
          r1   <= stride_random;
          span <= (modulus > INDEX_BITS'(3)) ? (modulus - INDEX_BITS'(3)) : '0;
        end
      end
      OP_MUL: begin
        prod <= PROD_BITS'(r1) * PROD_BITS'(span);
      end
      OP_CAND: begin
        // scaled candidate: floor(r1 * span / 2^31) + 2
        cand <= prod[PROD_BITS-1:RAND_BITS] + INDEX_BITS'(2);
      end
      OP_INC: begin
        cand <= cand + INDEX_BITS'(1);
      end
      OP_CAP_S: begin
        if (!rem_busy) begin
          smod <= rem_result;
        end
      end
      OP_ZERO: begin
        smod <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      sample_index <= cur;
      last         <= is_last;
    end
  end

  a_idle_rem: assert property (@(posedge clk) disable iff (rst) in_ready |-> !rem_busy)
    else $error("remainder unit busy while taking an item");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> emitted_count < sample_count)
    else $error("index emitted beyond the run length");
  a_stride_set: assert property (@(posedge clk) disable iff (rst)
    op == OP_REM_S |=> stride == $past(cand))
    else $error("stride not taken from the coprime candidate");

endmodule
